// ===== design/fixed_gain_position_velocity_tracker_assert.svh =====
// Assertion macros shared by the tracker RTL.
// Each macro expects clk and rst in scope and is disabled while rst is high.
`ifndef FIXED_GAIN_POSITION_VELOCITY_TRACKER_ASSERT_SVH
`define FIXED_GAIN_POSITION_VELOCITY_TRACKER_ASSERT_SVH

// Same-cycle implication
`define FGPVT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication
`define FGPVT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== design/fgpvt_pkg.sv =====
// ----------------------------------------------------------------------------
// fgpvt_pkg
// Types and constants shared by the fixed-gain position/velocity tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package fgpvt_pkg;

  // Field and register widths
  localparam int FIELD_W    = 32;
  localparam int STEP_W     = 24;
  localparam int GAIN_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL_Y = 3'd4;

  // Register reset values
  localparam logic [STEP_W-1:0]        STEP_TIME_RST = 24'd65536;
  localparam logic signed [GAIN_W-1:0] GAIN_POS_RST  = 18'sd43691;
  localparam logic signed [GAIN_W-1:0] GAIN_VEL_RST  = 18'sd4369;

  // Opcodes
  localparam logic OP_TRACK   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Sequencer steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_PRED,
    ST_ADD_PRED,
    ST_MUL_POS,
    ST_MUL_VEL,
    ST_FINISH
  } state_t;

  // Control from the sequencer to each lane
  typedef struct packed {
    logic   load;
    state_t step;
    logic   commit;
  } lane_ctl_t;

  typedef struct packed {
    logic                       opcode;
    logic signed [FIELD_W-1:0]  pos_x_in;
    logic signed [FIELD_W-1:0]  pos_y_in;
    logic signed [FIELD_W-1:0]  vel_x_in;
    logic signed [FIELD_W-1:0]  vel_y_in;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] est_pos_x;
    logic signed [FIELD_W-1:0] est_vel_x;
    logic signed [FIELD_W-1:0] est_pos_y;
    logic signed [FIELD_W-1:0] est_vel_y;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/fgpvt_stream_if.sv =====
// ----------------------------------------------------------------------------
// fgpvt_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface fgpvt_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/fgpvt_lane.sv =====
// ----------------------------------------------------------------------------
// fgpvt_lane
// One axis of the tracker: position/velocity state and a shared multiplier
// stepped through predict, residual and correction by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module fgpvt_lane #(
  parameter int VALUE_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire fgpvt_pkg::lane_ctl_t                  ctl,
  input  wire logic [fgpvt_pkg::STEP_W-1:0]          step_time,
  input  wire logic signed [fgpvt_pkg::GAIN_W-1:0]   gain_pos,
  input  wire logic signed [fgpvt_pkg::GAIN_W-1:0]   gain_vel,
  input  wire logic                                  opcode,
  input  wire logic signed [fgpvt_pkg::FIELD_W-1:0]  pos_in,
  input  wire logic signed [fgpvt_pkg::FIELD_W-1:0]  vel_in,
  output logic signed [VALUE_WIDTH-1:0]              est_pos,
  output logic signed [VALUE_WIDTH-1:0]              est_vel
);
  import fgpvt_pkg::*;

  // Residual width covers a 32-bit measurement against a state value
  localparam int RW  = ((VALUE_WIDTH > FIELD_W) ? VALUE_WIDTH : FIELD_W) + 1;
  localparam int MBW = STEP_W + 1;
  localparam int PW  = RW + MBW;
  localparam int RDW = PW + 1 - FRAC_BITS;
  localparam int SW  = RDW + 1;

  logic signed [VALUE_WIDTH-1:0] pos;
  logic signed [VALUE_WIDTH-1:0] vel;
  logic signed [VALUE_WIDTH-1:0] pred;
  logic signed [VALUE_WIDTH-1:0] pos_new;
  logic signed [FIELD_W-1:0]     meas;
  logic signed [FIELD_W-1:0]     vel_load;
  logic                          restart;
  logic signed [RW-1:0]          res;
  logic signed [PW-1:0]          prod;

  logic signed [RW-1:0]          res_next;
  logic signed [RW-1:0]          mul_a;
  logic signed [MBW-1:0]         mul_b;
  logic signed [PW-1:0]          mul_p;
  logic signed [PW:0]            rnd_sum;
  logic signed [RDW-1:0]         rnd;

  // Clamp a wide sum to the signed state range
  function automatic logic signed [VALUE_WIDTH-1:0] sat_value(
    input logic signed [SW-1:0] v
  );
    logic [SW-VALUE_WIDTH:0] top;
    top = v[SW-1:VALUE_WIDTH-1];
    if ((&top) || (~|top)) begin
      sat_value = v[VALUE_WIDTH-1:0];
    end else if (v[SW-1]) begin
      sat_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  endfunction

  // Residual against the predicted position
  assign res_next = RW'(meas) - RW'(pred);

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.step)
      ST_MUL_PRED: begin
        mul_a = RW'(vel);
        mul_b = $signed({1'b0, step_time});
      end
      ST_MUL_POS: begin
        mul_a = res_next;
        mul_b = MBW'(gain_pos);
      end
      ST_MUL_VEL: begin
        mul_a = res;
        mul_b = MBW'(gain_vel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round half up from Q.32 back to Q.16
  assign rnd_sum = (PW+1)'(prod) + (PW+1)'(ROUND_BIAS);
  assign rnd     = $signed(rnd_sum[PW:FRAC_BITS]);

  // New estimates, loaded at commit
  always_comb begin
    if (restart) begin
      est_pos = sat_value(SW'(meas));
      est_vel = sat_value(SW'(vel_load));
    end else begin
      est_pos = pos_new;
      est_vel = sat_value(SW'(vel) + SW'(rnd));
    end
  end

  // Capture the word and run the datapath steps
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      meas     <= pos_in;
      vel_load <= vel_in;
      restart  <= (opcode == OP_RESTART);
    end
    case (ctl.step)
      ST_MUL_PRED: begin
        prod <= mul_p;
      end
      ST_ADD_PRED: begin
        pred <= sat_value(SW'(pos) + SW'(rnd));
      end
      ST_MUL_POS: begin
        res  <= res_next;
        prod <= mul_p;
      end
      ST_MUL_VEL: begin
        pos_new <= sat_value(SW'(pred) + SW'(rnd));
        prod    <= mul_p;
      end
      default: begin
      end
    endcase
  end

  // Hold the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else if (ctl.commit) begin
      pos <= est_pos;
      vel <= est_vel;
    end
  end

endmodule

`default_nettype wire

// ===== design/fgpvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fgpvt_ctrl
// Configuration registers, step sequencer for both lanes, and the output
// register that merges the two lanes into one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module fgpvt_ctrl #(
  parameter int VALUE_WIDTH
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_we,
  input  wire logic [fgpvt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [fgpvt_pkg::CFG_DATA_W-1:0]        cfg_data,
  fgpvt_stream_if.sink                                 req,
  fgpvt_stream_if.source                               rsp,
  output fgpvt_pkg::lane_ctl_t                         lane_ctl,
  output logic [fgpvt_pkg::STEP_W-1:0]                 step_time,
  output logic signed [fgpvt_pkg::GAIN_W-1:0]          gain_pos_x,
  output logic signed [fgpvt_pkg::GAIN_W-1:0]          gain_vel_x,
  output logic signed [fgpvt_pkg::GAIN_W-1:0]          gain_pos_y,
  output logic signed [fgpvt_pkg::GAIN_W-1:0]          gain_vel_y,
  input  wire logic signed [VALUE_WIDTH-1:0]           lane_x_pos,
  input  wire logic signed [VALUE_WIDTH-1:0]           lane_x_vel,
  input  wire logic signed [VALUE_WIDTH-1:0]           lane_y_pos,
  input  wire logic signed [VALUE_WIDTH-1:0]           lane_y_vel
);
  import fgpvt_pkg::*;

  localparam int EW = VALUE_WIDTH + FIELD_W;

  state_t    state;
  state_t    state_next;
  logic      out_valid;
  out_word_t out_data;
  logic      in_acc;
  logic      out_free;

  logic signed [EW-1:0] px_ext;
  logic signed [EW-1:0] vx_ext;
  logic signed [EW-1:0] py_ext;
  logic signed [EW-1:0] vy_ext;

  // Configuration writes; out-of-range indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time  <= STEP_TIME_RST;
      gain_pos_x <= GAIN_POS_RST;
      gain_vel_x <= GAIN_VEL_RST;
      gain_pos_y <= GAIN_POS_RST;
      gain_vel_y <= GAIN_VEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_TIME:  step_time  <= cfg_data[STEP_W-1:0];
        REG_GAIN_POS_X: gain_pos_x <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_VEL_X: gain_vel_x <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_POS_Y: gain_pos_y <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GAIN_VEL_Y: gain_vel_y <= $signed(cfg_data[GAIN_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign in_acc    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next step and lane controls
  always_comb begin
    state_next      = state;
    lane_ctl.load   = 1'b0;
    lane_ctl.step   = state;
    lane_ctl.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          lane_ctl.load = 1'b1;
          state_next = (req.data.opcode == OP_RESTART) ? ST_FINISH : ST_MUL_PRED;
        end
      end
      ST_MUL_PRED: state_next = ST_ADD_PRED;
      ST_ADD_PRED: state_next = ST_MUL_POS;
      ST_MUL_POS:  state_next = ST_MUL_VEL;
      ST_MUL_VEL:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          lane_ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Merge the lanes into one 32-bit-per-field word
  assign px_ext = EW'(lane_x_pos);
  assign vx_ext = EW'(lane_x_vel);
  assign py_ext = EW'(lane_y_pos);
  assign vy_ext = EW'(lane_y_vel);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ctl.commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctl.commit) begin
      out_data.est_pos_x <= px_ext[FIELD_W-1:0];
      out_data.est_vel_x <= vx_ext[FIELD_W-1:0];
      out_data.est_pos_y <= py_ext[FIELD_W-1:0];
      out_data.est_vel_y <= vy_ext[FIELD_W-1:0];
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`include "fixed_gain_position_velocity_tracker_assert.svh"

  `FGPVT_ASSERT_NXT(a_track_starts, in_acc && (req.data.opcode == OP_TRACK), state == ST_MUL_PRED)
  `FGPVT_ASSERT_NXT(a_restart_skips, in_acc && (req.data.opcode == OP_RESTART), state == ST_FINISH)
  `FGPVT_ASSERT_NXT(a_commit_shows, lane_ctl.commit, rsp.valid && (state == ST_IDLE))
  `FGPVT_ASSERT_IMP(a_no_overwrite, lane_ctl.commit, !out_valid || rsp.ready)

endmodule

`default_nettype wire

// ===== design/fixed_gain_position_velocity_tracker.sv =====
// ----------------------------------------------------------------------------
// fixed_gain_position_velocity_tracker
// Two-axis fixed-gain (alpha-beta) tracker in signed Q16.16, one lane per axis.
// ----------------------------------------------------------------------------
//   channel   dir  handshake         word
//   req       in   valid/ready       opcode, pos_x_in, pos_y_in, vel_x_in, vel_y_in
//   rsp       out  valid/ready       est_pos_x, est_vel_x, est_pos_y, est_vel_y
//   cfg       in   cfg_we            cfg_index, cfg_data
//
// Between acceptances a track word steps through MUL_PRED, ADD_PRED, MUL_POS,
// MUL_VEL and FINISH; a restart goes to FINISH. The per-lane multiplier is used
// in turn for step_time*velocity, gain_pos*residual and gain_vel*residual.
// Reset clears the state and loads the register defaults; no clearing pass.
// A stalled result sits in the output register; the next word is still taken
// and computed, then waits in the final step with req ready low until it frees.
`default_nettype none

module fixed_gain_position_velocity_tracker #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [fgpvt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fgpvt_pkg::CFG_DATA_W-1:0]   cfg_data,
  fgpvt_stream_if.sink                            req,
  fgpvt_stream_if.source                          rsp
);
  import fgpvt_pkg::*;

  lane_ctl_t                     lane_ctl;
  logic [STEP_W-1:0]             step_time;
  logic signed [GAIN_W-1:0]      gain_pos_x;
  logic signed [GAIN_W-1:0]      gain_vel_x;
  logic signed [GAIN_W-1:0]      gain_pos_y;
  logic signed [GAIN_W-1:0]      gain_vel_y;
  logic signed [VALUE_WIDTH-1:0] x_pos;
  logic signed [VALUE_WIDTH-1:0] x_vel;
  logic signed [VALUE_WIDTH-1:0] y_pos;
  logic signed [VALUE_WIDTH-1:0] y_vel;

  // Sequencer, registers and result merge
  fgpvt_ctrl #(.VALUE_WIDTH(VALUE_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req),
    .rsp        (rsp),
    .lane_ctl   (lane_ctl),
    .step_time  (step_time),
    .gain_pos_x (gain_pos_x),
    .gain_vel_x (gain_vel_x),
    .gain_pos_y (gain_pos_y),
    .gain_vel_y (gain_vel_y),
    .lane_x_pos (x_pos),
    .lane_x_vel (x_vel),
    .lane_y_pos (y_pos),
    .lane_y_vel (y_vel)
  );

  // X axis lane
  fgpvt_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .step_time (step_time),
    .gain_pos  (gain_pos_x),
    .gain_vel  (gain_vel_x),
    .opcode    (req.data.opcode),
    .pos_in    (req.data.pos_x_in),
    .vel_in    (req.data.vel_x_in),
    .est_pos   (x_pos),
    .est_vel   (x_vel)
  );

  // Y axis lane
  fgpvt_lane #(.VALUE_WIDTH(VALUE_WIDTH)) u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .step_time (step_time),
    .gain_pos  (gain_pos_y),
    .gain_vel  (gain_vel_y),
    .opcode    (req.data.opcode),
    .pos_in    (req.data.pos_y_in),
    .vel_in    (req.data.vel_y_in),
    .est_pos   (y_pos),
    .est_vel   (y_vel)
  );

endmodule

`default_nettype wire
